// ===== design/iss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

   // Default depth of the sequence
   localparam int CAPACITY_DEF = 64;

   // Field widths
   localparam int OP_W    = 3;
   localparam int POS_W   = 8;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;

   // Operation codes
   localparam logic [OP_W-1:0] OP_READ     = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
   localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // Broadcast control from the decoder to every cell
   typedef struct packed {
      logic ins;   // open a slot at pos, shift later entries up
      logic del;   // drop the entry at pos, shift later entries down
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== design/iss_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iss_cell
   import iss_pkg::*;
#(
   parameter int IDX_W    = 6,
   parameter int CELL_IDX = 0
) (
   input  wire                clock,
   input  wire cell_ctrl_type ctrl,
   input  wire [IDX_W-1:0]    pos,
   input  wire [DATA_W-1:0]   ins_value,
   input  wire [DATA_W-1:0]   left_data,
   input  wire [DATA_W-1:0]   right_data,
   output logic [DATA_W-1:0]  data,
   output logic [DATA_W-1:0]  rd_data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              at_pos;
   logic              past_pos;

   assign at_pos   = (pos == MY_IDX);
   assign past_pos = (MY_IDX > pos);

   // Shift, load or hold
   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (at_pos) begin
            data_in = ins_value;
         end else if (past_pos) begin
            data_in = left_data;
         end
      end else if (ctrl.del) begin
         if (at_pos || past_pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   // Read tap: only the addressed cell drives the shared OR bus
   assign rd_data = at_pos ? data_ff : '0;

endmodule

`default_nettype wire

// ===== design/indexed_sequence_store_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered store of up to CAPACITY signed 32-bit values.
// Request channel (req_*): operation in tuser; position and value in tdata.
//   Operations: read at index, insert at head, insert at tail, insert at
//   index, delete at index. Inserts shift later entries up, deletes shift
//   them down.
// Response channel (rsp_*): one response per request, carrying read_value,
//   status (done, index out of range, store full) and the entry count after
//   the operation.
// The entries sit in a row of cells; every cell shifts, loads or holds in
// the same cycle, so a whole request is applied at once. The response is
// in the output register in the cycle after the request is taken, and a
// request can be taken every cycle. Reads pick the addressed cell through
// an OR bus. When the receiver stalls, the response holds and a new
// request is taken only in a cycle where the held response leaves.
// Reset empties the store (entry count zero) and drops any pending response;
// the cell contents are not cleared and are never read before written.
module indexed_sequence_store_top
   import iss_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // [7:0] position, [39:8] value
   input  wire  [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata    // [31:0] read_value, [33:32] status,
                                    // [40:34] entry_count, [47:41] zero
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // Request fields
   logic [OP_W-1:0]   op;
   logic [POS_W-1:0]  pos_raw;
   logic [DATA_W-1:0] value;
   assign op      = req_tuser[OP_W-1:0];
   assign pos_raw = req_tdata[POS_W-1:0];
   assign value   = req_tdata[POS_W +: DATA_W];

   // Control registers
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rd_value_ff, rd_value_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [COUNT_W-1:0] entry_ff, entry_in;

   logic accept;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Index checks
   logic             pos_neg;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] occ_ext;
   logic             full;
   logic             idx_ok_rd;
   logic             idx_ok_ins;
   assign pos_neg    = pos_raw[POS_W-1];
   assign pos_ext    = CMP_W'(pos_raw);
   assign occ_ext    = CMP_W'(count_ff);
   assign full       = (count_ff >= CNT_W'(CAPACITY));
   assign idx_ok_rd  = !pos_neg && (pos_ext < occ_ext);
   assign idx_ok_ins = !pos_neg && (pos_ext <= occ_ext);

   // Cell row
   cell_ctrl_type     ctrl;
   logic [IDX_W-1:0]  cell_pos;
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_rd   [CAPACITY];
   logic [DATA_W-1:0] rd_bus;

   // Decode
   always_comb begin
      ctrl        = '0;
      cell_pos    = pos_ext[IDX_W-1:0];
      rd_value_in = '0;
      status_in   = ST_DONE;
      count_in    = count_ff;
      unique case (op)
         OP_READ: begin
            if (idx_ok_rd) begin
               rd_value_in = rd_bus;
            end else begin
               rd_value_in = '1;
               status_in   = ST_RANGE;
            end
         end
         OP_INS_HEAD: begin
            cell_pos = '0;
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.ins = accept;
               count_in = count_ff + 1'b1;
            end
         end
         OP_INS_TAIL: begin
            cell_pos = occ_ext[IDX_W-1:0];
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.ins = accept;
               count_in = count_ff + 1'b1;
            end
         end
         OP_INS_AT: begin
            if (!idx_ok_ins) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.ins = accept;
               count_in = count_ff + 1'b1;
            end
         end
         OP_DELETE: begin
            if (idx_ok_rd) begin
               ctrl.del = accept;
               count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   // Entry count reported as its low bits
   logic [EXT_W-1:0] count_wide;
   assign count_wide = EXT_W'(count_in);
   assign entry_in   = count_wide[COUNT_W-1:0];

   // Read bus: OR of the masked cell taps
   always_comb begin
      rd_bus = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_bus = rd_bus | cell_rd[i];
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      if (g == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_data[g+1];
      end
      iss_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (cell_pos),
         .ins_value  (value),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[g]),
         .rd_data    (cell_rd[g])
      );
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_value_ff <= rd_value_in;
         status_ff   <= status_in;
         entry_ff    <= entry_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, entry_ff, status_ff, rd_value_ff};

endmodule

`default_nettype wire

// ===== test/indexed_sequence_store_top_tb.sv =====
`timescale 1ns / 1ps

module indexed_sequence_store_top_tb;
   import iss_pkg::*;

   localparam int DEPTH = CAPACITY_DEF;
   localparam int IDLE_PCT = 13;
   localparam int RANDOM_ITEMS = 1150;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 10;

   // Codes past the last defined operation; the store must ignore them
   localparam logic [OP_W-1:0] OP_UNDEF_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_UNDEF_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_7 = 3'd7;

   typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_kind_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_value;
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] count;
   } seq_response_type;

   // Mirror of the sequence; predicts one response per accepted request
   class sequence_scoreboard;
      logic [DATA_W-1:0] mirror [DEPTH];
      int unsigned mirror_count;
      seq_response_type predicted_responses[$];
      int unsigned mismatches;
      int unsigned printed;

      task report(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         mismatches++;
         if (printed < 40) begin
            printed++;
            $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
         end
      endtask

      function void insert_at(int unsigned at, logic [DATA_W-1:0] val);
         for (int i = mirror_count; i > at; i--)
            mirror[i] = mirror[i-1];
         mirror[at] = val;
         mirror_count++;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [DATA_W-1:0] val);
         seq_response_type res;
         logic negative;
         logic full;
         int unsigned idx;
         res = '0;
         negative = pos[POS_W-1];
         full = (mirror_count >= DEPTH);
         idx = 32'(pos);
         case (op)
            OP_READ: begin
               if (negative || idx >= mirror_count) begin
                  res.read_value = '1;
                  res.status = ST_RANGE;
               end else begin
                  res.read_value = mirror[idx];
               end
            end
            OP_INS_HEAD: begin
               if (full) res.status = ST_FULL;
               else insert_at(0, val);
            end
            OP_INS_TAIL: begin
               if (full) res.status = ST_FULL;
               else insert_at(mirror_count, val);
            end
            OP_INS_AT: begin
               // bad index wins over full store
               if (negative || idx > mirror_count) res.status = ST_RANGE;
               else if (full) res.status = ST_FULL;
               else insert_at(idx, val);
            end
            OP_DELETE: begin
               if (negative || idx >= mirror_count) begin
                  res.status = ST_RANGE;
               end else begin
                  for (int i = idx; i + 1 < mirror_count; i++)
                     mirror[i] = mirror[i+1];
                  mirror_count--;
               end
            end
            default: ;
         endcase
         res.count = mirror_count[COUNT_W-1:0];
         predicted_responses = {predicted_responses, res};
      endfunction

      task check_response(logic [47:0] data);
         seq_response_type want;
         if (predicted_responses.size() == 0) begin
            report("response with none pending", data[31:0], '0);
            return;
         end
         want = predicted_responses.pop_front();
         if (data[31:0] !== want.read_value)
            report("read_value", data[31:0], want.read_value);
         if (data[33:32] !== want.status)
            report("status", DATA_W'(data[33:32]), DATA_W'(want.status));
         if (data[40:34] !== want.count)
            report("entry_count", DATA_W'(data[40:34]), DATA_W'(want.count));
      endtask

      function int unsigned pending();
         return predicted_responses.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic [39:0] req_tdata = '0;   // [7:0] position, [39:8] value
   logic [2:0] req_tuser = '0;    // [2:0] operation
   logic rsp_tready = 1'b0;
   wire req_tready;
   wire rsp_tvalid;
   wire [47:0] rsp_tdata;         // [31:0] read_value, [33:32] status, [40:34] entry_count

   sequence_scoreboard board;
   logic steady = 1'b0;           // suppresses idling on both sides
   int unsigned quiet_cycles = 0;

   indexed_sequence_store_top #(.CAPACITY(DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Response side: check on handshake, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata);
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Drive one request, with an optional random gap first
   task send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {val, pos};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, pos, val);
   endtask

   function logic [DATA_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6) return 32'h7FFF_FFFF;
      if (r < 12) return 32'h8000_0000;
      if (r < 16) return '0;
      if (r < 20) return '1;
      return $urandom;
   endfunction

   // Position: mostly a valid index, sometimes an edge or any byte
   function logic [POS_W-1:0] pick_position(int unsigned limit);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) return POS_W'($urandom_range(255));
      if (r < 11) return POS_W'(limit);
      if (r < 13) return 8'h80;
      if (r < 15) return 8'h7F;
      if (limit == 0) return '0;
      return POS_W'($urandom_range(limit - 1));
   endfunction

   task random_request(phase_kind_type kind);
      int unsigned r;
      int unsigned n;
      int unsigned ins_pct;
      int unsigned del_pct;
      logic [OP_W-1:0] op;
      logic [POS_W-1:0] pos;
      n = board.mirror_count;
      case (kind)
         PH_GROW: begin ins_pct = 78; del_pct = 8; end
         PH_SHRINK: begin ins_pct = 14; del_pct = 70; end
         default: begin ins_pct = 42; del_pct = 35; end
      endcase
      r = $urandom_range(99);
      if (r < 4) begin
         // noise: any code, any position
         op = OP_W'($urandom_range(7));
         pos = POS_W'($urandom_range(255));
      end else if (r < 4 + ins_pct) begin
         case ($urandom_range(2))
            0: op = OP_INS_HEAD;
            1: op = OP_INS_TAIL;
            default: op = OP_INS_AT;
         endcase
         pos = (op == OP_INS_AT) ? pick_position(n + 1) : pick_position(n);
      end else if (r < 4 + ins_pct + del_pct) begin
         op = OP_DELETE;
         pos = pick_position(n);
      end else begin
         op = OP_READ;
         pos = pick_position(n);
      end
      send_request(op, pos, pick_value());
   endtask

   initial begin
      phase_kind_type kind;
      int unsigned phase_left;
      board = new;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, bad indexes, appends, extremes, spare codes
      send_request(OP_READ, 8'd0, 32'h1234_5678);
      send_request(OP_DELETE, 8'd0, '0);
      send_request(OP_INS_AT, 8'hFF, 32'h1111_1111);
      send_request(OP_INS_AT, 8'd1, 32'h2222_2222);
      send_request(OP_INS_AT, 8'd0, 32'h7FFF_FFFF);
      send_request(OP_INS_HEAD, 8'h80, 32'h8000_0000);
      send_request(OP_INS_TAIL, 8'h7F, 32'hFFFF_FFFF);
      send_request(OP_INS_AT, 8'd3, 32'h0000_0000);
      send_request(OP_INS_AT, 8'd2, 32'h5A5A_5A5A);
      send_request(OP_READ, 8'h80, '0);
      send_request(OP_READ, 8'h7F, '0);
      send_request(OP_READ, 8'd4, '0);
      send_request(OP_READ, 8'd5, '0);
      send_request(OP_READ, 8'd0, 32'hA5A5_A5A5);
      send_request(OP_UNDEF_5, 8'd0, 32'hDEAD_BEEF);
      send_request(OP_UNDEF_6, 8'hFF, 32'hFFFF_FFFF);
      send_request(OP_UNDEF_7, 8'h55, 32'h0F0F_0F0F);
      send_request(OP_DELETE, 8'h80, '0);
      send_request(OP_DELETE, 8'h7F, '0);
      send_request(OP_DELETE, 8'd5, '0);
      send_request(OP_DELETE, 8'd0, '0);
      send_request(OP_DELETE, 8'd3, '0);
      send_request(OP_READ, 8'd2, '0);

      // Random: phases that fill toward full, drain toward empty, or mix
      kind = PH_GROW;
      phase_left = 100;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady <= (i >= 500 && i < 700);
         if (phase_left == 0) begin
            kind = phase_kind_type'($urandom_range(2));
            phase_left = $urandom_range(120, 40);
         end
         phase_left--;
         random_request(kind);
      end
      req_tvalid <= 1'b0;
      steady <= 1'b0;

      // Wait for every response, then keep the clock running to catch stray output
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
